// ===== hw/rtl/gmds_pkg.sv =====
package gmds_pkg;

    localparam int OP_W    = 2;
    localparam int COORD_W = 6;
    localparam int CFG_W   = 7;
    localparam int MARK_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_SEARCH = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [MARK_W-1:0] {
        MARK_OPEN = 2'd0,
        MARK_WALL = 2'd1,
        MARK_PATH = 2'd2,
        MARK_DEAD = 2'd3
    } t_mark;

    // walk directions, tried in this order
    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } t_dir;

    typedef enum logic [0:0] {
        CFG_GRID_ROWS = 1'b0,
        CFG_GRID_COLS = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_START,
        S_START_CHK,
        S_PROBE,
        S_PROBE_CHK,
        S_POP
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               is_wall;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [MARK_W-1:0] cell_mark;
    } t_out_item;

endpackage

// ===== hw/rtl/grid_maze_dfs_solver.sv =====
// A write or unused operation gives its result directly; a read waits on the RAM;
// a search checks the start, probes neighbours in turn (off-grid ones need no RAM
// read) and backtracks, paced by one RAM port. A write every cycle unless output
// stalls; input stalls while an item is in progress or a finished result is held by
// output stall. Reset (synchronous, active low) clears control state and sets both
// grid sizes to 64; the maze RAM and direction stack are not cleared.
module grid_maze_dfs_solver
    import gmds_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [0:0]           i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int RW    = $clog2(MAX_ROWS);      // row coordinate bits
    localparam int CW    = $clog2(MAX_COLS);      // column coordinate bits
    localparam int RUW   = RW + 1;                // holds row count up to MAX_ROWS
    localparam int CUW   = CW + 1;
    localparam int CAW   = RW + CW;               // cell address {row, col}
    localparam int CDEP  = MAX_ROWS << CW;
    localparam int CELLS = MAX_ROWS * MAX_COLS;   // stack capacity
    localparam int SAW   = $clog2(CELLS);
    localparam int SDW   = $clog2(CELLS + 1);

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    t_state           r_state, n_state;
    logic [RW-1:0]    r_walk_row, n_walk_row;
    logic [CW-1:0]    r_walk_col, n_walk_col;
    logic [SDW-1:0]   r_depth, n_depth;
    logic [2:0]       r_next, n_next;         // next direction to try; 4 = exhausted
    logic             r_oob, n_oob;           // pending read lies outside the grid
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;
    logic [CFG_W-1:0] r_grid_rows, r_grid_cols;

    // ---------------------------------------------------------------
    // effective grid size, clamped to 3..MAX
    // ---------------------------------------------------------------
    logic [RUW-1:0] rows_used;
    logic [CUW-1:0] cols_used;
    logic [RW-1:0]  goal_row;
    logic [CW-1:0]  goal_col;

    always_comb begin
        if (int'(r_grid_rows) < 3) begin
            rows_used = RUW'(3);
        end else if (int'(r_grid_rows) > MAX_ROWS) begin
            rows_used = RUW'(MAX_ROWS);
        end else begin
            rows_used = RUW'(r_grid_rows);
        end
        if (int'(r_grid_cols) < 3) begin
            cols_used = CUW'(3);
        end else if (int'(r_grid_cols) > MAX_COLS) begin
            cols_used = CUW'(MAX_COLS);
        end else begin
            cols_used = CUW'(r_grid_cols);
        end
    end

    assign goal_row = RW'(rows_used - RUW'(2));
    assign goal_col = CW'(cols_used - CUW'(2));

    // ---------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------
    logic in_acc;
    logic out_take;

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    // sizes may only move between items
    assign o_cfg_ready = (r_state == S_IDLE);

    // input cell inside the grid in use
    logic          in_inside;
    logic [CAW-1:0] in_addr;

    assign in_inside = (int'(i_in_data.row) < int'(rows_used)) &&
                       (int'(i_in_data.col) < int'(cols_used));
    assign in_addr   = {RW'(i_in_data.row), CW'(i_in_data.col)};

    // ---------------------------------------------------------------
    // neighbour in direction r_next; off-grid counts as wall
    // ---------------------------------------------------------------
    logic [RW-1:0] nb_row;
    logic [CW-1:0] nb_col;
    logic          nb_out;

    always_comb begin
        nb_row = r_walk_row;
        nb_col = r_walk_col;
        nb_out = 1'b0;
        case (t_dir'(r_next[1:0]))
            DIR_RIGHT: begin
                nb_col = r_walk_col + CW'(1);
                nb_out = ({1'b0, r_walk_col} + CUW'(1)) >= cols_used;
            end
            DIR_LEFT: begin
                nb_col = r_walk_col - CW'(1);
                nb_out = (r_walk_col == '0);
            end
            DIR_UP: begin
                nb_row = r_walk_row - RW'(1);
                nb_out = (r_walk_row == '0);
            end
            DIR_DOWN: begin
                nb_row = r_walk_row + RW'(1);
                nb_out = ({1'b0, r_walk_row} + RUW'(1)) >= rows_used;
            end
            default: begin
                nb_out = 1'b1;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // memories: cell marks and direction stack
    // ---------------------------------------------------------------
    logic              cm_we, cm_re;
    logic [CAW-1:0]    cm_waddr, cm_raddr;
    logic [MARK_W-1:0] cm_wdata, cm_rdata;
    logic              st_we, st_re;
    logic [SAW-1:0]    st_waddr, st_raddr;
    logic [1:0]        st_wdata, st_rdata;

    gmds_ram #(
        .WIDTH (MARK_W),
        .DEPTH (CDEP)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cm_we),
        .i_waddr (cm_waddr),
        .i_wdata (cm_wdata),
        .i_re    (cm_re),
        .i_raddr (cm_raddr),
        .o_rdata (cm_rdata)
    );

    gmds_ram #(
        .WIDTH (2),
        .DEPTH (CELLS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_walk_row  = r_walk_row;
        n_walk_col  = r_walk_col;
        n_depth     = r_depth;
        n_next      = r_next;
        n_oob       = r_oob;
        n_out_valid = r_out_valid && !out_take;
        n_out       = r_out;
        cm_we       = 1'b0;
        cm_waddr    = {r_walk_row, r_walk_col};
        cm_wdata    = MARK_PATH;
        cm_re       = 1'b0;
        cm_raddr    = {nb_row, nb_col};
        st_we       = 1'b0;
        st_waddr    = r_depth[SAW-1:0];
        st_wdata    = r_next[1:0];
        st_re       = 1'b0;
        st_raddr    = SAW'(r_depth - SDW'(1));

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.operation)
                        OP_WRITE: begin
                            cm_we       = in_inside;
                            cm_waddr    = in_addr;
                            cm_wdata    = i_in_data.is_wall ? MARK_WALL : MARK_OPEN;
                            n_out_valid = 1'b1;
                            n_out       = '0;
                        end
                        OP_READ: begin
                            cm_re    = 1'b1;
                            cm_raddr = in_addr;
                            n_oob    = !in_inside;
                            n_state  = S_RD_WAIT;
                        end
                        OP_SEARCH: begin
                            n_walk_row = RW'(1);
                            n_walk_col = CW'(1);
                            n_depth    = '0;
                            n_state    = S_START;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out       = '0;
                        end
                    endcase
                end
            end

            S_RD_WAIT: begin
                n_out_valid     = 1'b1;
                n_out.found     = 1'b0;
                n_out.cell_mark = r_oob ? MARK_WALL : cm_rdata;
                n_state         = S_IDLE;
            end

            S_START: begin
                if (r_walk_row == goal_row && r_walk_col == goal_col) begin
                    // 3x3 grid: start is the goal
                    cm_we       = 1'b1;
                    n_out_valid = 1'b1;
                    n_out       = '{found: 1'b1, cell_mark: MARK_OPEN};
                    n_state     = S_IDLE;
                end else begin
                    cm_re    = 1'b1;
                    cm_raddr = {r_walk_row, r_walk_col};
                    n_state  = S_START_CHK;
                end
            end

            S_START_CHK: begin
                if (t_mark'(cm_rdata) == MARK_WALL || t_mark'(cm_rdata) == MARK_PATH) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_state     = S_IDLE;
                end else begin
                    cm_we   = 1'b1;
                    n_next  = 3'd0;
                    n_state = S_PROBE;
                end
            end

            S_PROBE: begin
                if (r_next[2]) begin
                    // every way tried: dead end, back out
                    cm_we    = 1'b1;
                    cm_wdata = MARK_DEAD;
                    if (r_depth == '0) begin
                        n_out_valid = 1'b1;
                        n_out       = '0;
                        n_state     = S_IDLE;
                    end else begin
                        st_re   = 1'b1;
                        n_depth = r_depth - SDW'(1);
                        n_state = S_POP;
                    end
                end else if (nb_out) begin
                    n_next = r_next + 3'd1;
                end else begin
                    cm_re   = 1'b1;
                    n_state = S_PROBE_CHK;
                end
            end

            S_PROBE_CHK: begin
                if (t_mark'(cm_rdata) == MARK_OPEN && r_depth < SDW'(CELLS)) begin
                    st_we      = 1'b1;
                    n_depth    = r_depth + SDW'(1);
                    n_walk_row = nb_row;
                    n_walk_col = nb_col;
                    cm_we      = 1'b1;
                    cm_waddr   = {nb_row, nb_col};
                    if (nb_row == goal_row && nb_col == goal_col) begin
                        n_out_valid = 1'b1;
                        n_out       = '{found: 1'b1, cell_mark: MARK_OPEN};
                        n_state     = S_IDLE;
                    end else begin
                        n_next  = 3'd0;
                        n_state = S_PROBE;
                    end
                end else begin
                    n_next  = r_next + 3'd1;
                    n_state = S_PROBE;
                end
            end

            S_POP: begin
                // undo the step that entered this cell, resume with the next way
                unique case (t_dir'(st_rdata))
                    DIR_RIGHT: n_walk_col = r_walk_col - CW'(1);
                    DIR_LEFT:  n_walk_col = r_walk_col + CW'(1);
                    DIR_UP:    n_walk_row = r_walk_row + RW'(1);
                    DIR_DOWN:  n_walk_row = r_walk_row - RW'(1);
                    default:   n_walk_row = r_walk_row;
                endcase
                n_next  = {1'b0, st_rdata} + 3'd1;
                n_state = S_PROBE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_walk_row  <= '0;
            r_walk_col  <= '0;
            r_depth     <= '0;
            r_next      <= '0;
            r_oob       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_walk_row  <= n_walk_row;
            r_walk_col  <= n_walk_col;
            r_depth     <= n_depth;
            r_next      <= n_next;
            r_oob       <= n_oob;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= CFG_W'(64);
            r_grid_cols <= CFG_W'(64);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                CFG_GRID_COLS: r_grid_cols <= i_cfg_data;
                default:       r_grid_rows <= r_grid_rows;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_walk_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |->
            ({1'b0, r_walk_row} < rows_used) && ({1'b0, r_walk_col} < cols_used))
        else $error("walk left the grid");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= SDW'(CELLS))
        else $error("direction stack overflow");

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.operation == OP_WRITE) |=> (o_out_valid && !o_out_data.found))
        else $error("cell write gave no result");

    a_search_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.operation == OP_SEARCH) |=>
            (r_state == S_START && r_depth == '0))
        else $error("search did not start cleanly");

endmodule

// ===== hw/rtl/gmds_ram.sv =====
module gmds_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
